@@ rtl/bsfd_pkg.sv @@
// Shared types and constants for the byte-stuffing frame decoder.
// No dependencies; every other file in rtl/ imports this package.
package bsfd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SizeW  = 13;
  localparam int unsigned PosW   = 12;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [ByteW-1:0] StartFlagRst  = 8'hF7;
  localparam logic [ByteW-1:0] EndFlagRst    = 8'h7F;
  localparam logic [ByteW-1:0] EscapeFlagRst = 8'h7D;
  localparam logic [SizeW-1:0] BufSizeRst    = '0;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_START_FLAG  = 2'd0,
    REG_END_FLAG    = 2'd1,
    REG_ESCAPE_FLAG = 2'd2,
    REG_BUFFER_SIZE = 2'd3
  } reg_idx_e;

  typedef enum logic [0:0] {
    KIND_WRITE    = 1'b0,
    KIND_COMPLETE = 1'b1
  } result_kind_e;

  // One-hot parser states.
  typedef enum logic [2:0] {
    ST_IDLE     = 3'b001,
    ST_ACTIVE   = 3'b010,
    ST_ESCAPING = 3'b100
  } parse_state_e;

  typedef struct packed {
    logic [ByteW-1:0] start_flag;
    logic [ByteW-1:0] end_flag;
    logic [ByteW-1:0] escape_flag;
    logic [SizeW-1:0] buffer_size;
  } cfg_t;

  typedef struct packed {
    result_kind_e    kind;
    logic [ByteW-1:0] payload_byte;
    logic [PosW-1:0]  write_position;
    logic [PosW-1:0]  frame_length;
  } result_t;

endpackage

@@ rtl/bsfd_regs.sv @@
// Configuration registers of the frame decoder behind an APB-style port.
// Depends on bsfd_pkg for the register map and the cfg_t bundle.
module bsfd_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsfd_pkg::AddrW-1:0]  paddr,
  input  logic [bsfd_pkg::DataW-1:0]  pwdata,
  output logic [bsfd_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output bsfd_pkg::cfg_t              cfg_o
);
  import bsfd_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_START_FLAG:  cfg_d.start_flag  = pwdata[ByteW-1:0];
        REG_END_FLAG:    cfg_d.end_flag    = pwdata[ByteW-1:0];
        REG_ESCAPE_FLAG: cfg_d.escape_flag = pwdata[ByteW-1:0];
        REG_BUFFER_SIZE: cfg_d.buffer_size = pwdata[SizeW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_FLAG:  prdata = DataW'(cfg_q.start_flag);
      REG_END_FLAG:    prdata = DataW'(cfg_q.end_flag);
      REG_ESCAPE_FLAG: prdata = DataW'(cfg_q.escape_flag);
      REG_BUFFER_SIZE: prdata = DataW'(cfg_q.buffer_size);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_flag  <= StartFlagRst;
      cfg_q.end_flag    <= EndFlagRst;
      cfg_q.escape_flag <= EscapeFlagRst;
      cfg_q.buffer_size <= BufSizeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/bsfd_parse.sv @@
// Deframing state machine: parse state, write cursor and result decode for one byte.
// Depends on bsfd_pkg for the state encoding, cfg_t and result_t.
module bsfd_parse #(
  parameter int unsigned MAX_BUFFER = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [bsfd_pkg::ByteW-1:0] rx_byte_i,
  input  bsfd_pkg::cfg_t             cfg_i,
  output logic                       push_o,
  output bsfd_pkg::result_t          result_o
);
  import bsfd_pkg::*;

  // The cursor never exceeds the smaller of MAX_BUFFER - 1 and the largest
  // programmable size minus one.
  localparam int unsigned CurW  = (MAX_BUFFER > (1 << SizeW)) ? SizeW : $clog2(MAX_BUFFER);
  localparam int unsigned ExtW  = (CurW > PosW) ? CurW : PosW;
  localparam int unsigned CmpW  = 18;

  parse_state_e     state_q, state_d;
  logic [CurW-1:0]  cursor_q, cursor_d;
  logic [SizeW-1:0] eff_size;
  logic [CmpW-1:0]  cursor_inc;
  logic             enabled;
  logic             full;
  logic [ExtW-1:0]  cursor_ext;
  logic [PosW-1:0]  cursor_pos;

  // A programmed size above MAX_BUFFER behaves as MAX_BUFFER.
  assign eff_size   = (CmpW'(cfg_i.buffer_size) > CmpW'(MAX_BUFFER)) ?
                      SizeW'(MAX_BUFFER) : cfg_i.buffer_size;
  assign enabled    = (eff_size != '0);
  assign cursor_inc = CmpW'(cursor_q) + CmpW'(1);
  assign full       = (cursor_inc >= CmpW'(eff_size));
  assign cursor_ext = ExtW'(cursor_q);
  assign cursor_pos = cursor_ext[PosW-1:0];

  always_comb begin
    state_d  = state_q;
    cursor_d = cursor_q;
    push_o   = 1'b0;
    result_o = '{kind: KIND_WRITE, payload_byte: rx_byte_i,
                 write_position: cursor_pos, frame_length: '0};

    if (accept_i && enabled) begin
      case (state_q)
        ST_ESCAPING: begin
          // Any byte after an escape is literal payload.
          if (full) begin
            state_d = ST_IDLE;
          end else begin
            push_o   = 1'b1;
            cursor_d = cursor_inc[CurW-1:0];
            state_d  = ST_ACTIVE;
          end
        end
        ST_ACTIVE: begin
          if (rx_byte_i == cfg_i.start_flag) begin
            cursor_d = '0;
          end else if (rx_byte_i == cfg_i.end_flag) begin
            state_d  = ST_IDLE;
            push_o   = 1'b1;
            result_o = '{kind: KIND_COMPLETE, payload_byte: '0,
                         write_position: '0, frame_length: cursor_pos};
          end else if (rx_byte_i == cfg_i.escape_flag) begin
            state_d = ST_ESCAPING;
          end else if (full) begin
            state_d = ST_IDLE;
          end else begin
            push_o   = 1'b1;
            cursor_d = cursor_inc[CurW-1:0];
          end
        end
        default: begin
          // Idle: only a start flag matters.
          if (rx_byte_i == cfg_i.start_flag) begin
            state_d  = ST_ACTIVE;
            cursor_d = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cursor_q <= '0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
    end
  end

  a_disabled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !enabled) |=> ($stable(state_q) && $stable(cursor_q)))
    else $error("parser state moved while disabled");

  a_complete_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && result_o.kind == KIND_COMPLETE) |=> (state_q == ST_IDLE))
    else $error("frame completion did not return to idle");

  a_write_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && result_o.kind == KIND_WRITE) |=>
      (cursor_q == $past(cursor_q) + CurW'(1)) && (state_q == ST_ACTIVE))
    else $error("payload write did not advance the cursor");

endmodule

@@ rtl/bsfd_outreg.sv @@
// Result register with a skid stage that catches one further result under a stall.
// Depends on bsfd_pkg for result_t.
module bsfd_outreg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bsfd_pkg::result_t result_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bsfd_pkg::result_t result_o
);
  import bsfd_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign in_ready_o = !skid_valid_q;
  assign pop        = out_valid_q & out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop || !out_valid_q) begin
      out_valid_d  = skid_valid_q | push_i;
      out_d        = skid_valid_q ? skid_q : result_i;
      skid_valid_d = 1'b0;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = result_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds an item ahead of the output register");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid item not moved to the output register");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("result pushed while both stages are occupied");

endmodule

@@ rtl/byte_stuffing_frame_decoder.sv @@
// Top level of the byte-stuffing frame decoder (receive side).
// Depends on bsfd_pkg, bsfd_regs, bsfd_parse and bsfd_outreg.
//
// Usage
//   Raw link bytes arrive on the input channel (rx_byte_i, in_valid_i /
//   in_ready_o), one item per accepted byte. Each byte yields at most one
//   result item on the output channel (out_valid_o / out_ready_i): either a
//   payload write (result_kind_o = 0, with payload_byte_o at write_position_o)
//   or a frame completion (result_kind_o = 1, with frame_length_o).
//   Flag bytes and the buffer size are set through the APB-style port; they
//   should only be changed while no item is in flight.
// Timing
//   The parser state and cursor update in the cycle a byte is accepted, and
//   its result is registered in the output register, or in the skid stage
//   when that register is stalled. One byte is accepted every cycle for as
//   long as the result register and its skid stage are not both occupied.
// Reset and stalls
//   Reset returns the parser to idle with the cursor at zero, empties both
//   result stages and loads the default flags with a buffer size of zero,
//   which leaves the block disabled until the size is programmed. When the
//   receiver stalls, one further result is caught in the skid stage and
//   in_ready_o then drops until the receiver takes an item.
module byte_stuffing_frame_decoder #(
  parameter int unsigned MAX_BUFFER = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bsfd_pkg::AddrW-1:0]  paddr,
  input  logic [bsfd_pkg::DataW-1:0]  pwdata,
  output logic [bsfd_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  // Input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bsfd_pkg::ByteW-1:0]  rx_byte_i,
  // Output channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        result_kind_o,
  output logic [bsfd_pkg::ByteW-1:0]  payload_byte_o,
  output logic [bsfd_pkg::PosW-1:0]   write_position_o,
  output logic [bsfd_pkg::PosW-1:0]   frame_length_o
);
  import bsfd_pkg::*;

  cfg_t    cfg;
  logic    accept;
  logic    push;
  result_t result_new;
  result_t result_out;

  // A byte is taken when in_valid_i is high and the skid stage is free to catch its result.
  assign accept = in_valid_i & in_ready_o;

  bsfd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bsfd_parse #(
    .MAX_BUFFER (MAX_BUFFER)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg),
    .push_o    (push),
    .result_o  (result_new)
  );

  bsfd_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .result_i    (result_new),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_out)
  );

  assign result_kind_o    = result_out.kind;
  assign payload_byte_o   = result_out.payload_byte;
  assign write_position_o = result_out.write_position;
  assign frame_length_o   = result_out.frame_length;

endmodule
